/* rtl/tiny_four_register_cpu_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tiny four-register CPU
// Clocked on clk and disabled while rst_n is low in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef TINY_FOUR_REGISTER_CPU_DEFINES_SVH
`define TINY_FOUR_REGISTER_CPU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/tfrc_pkg.sv */
// ----------------------------------------------------------------------------
// tfrc_pkg
// Widths, command codes, instruction encodings and shared types.
// ----------------------------------------------------------------------------
package tfrc_pkg;

    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 8;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int NUM_REGS  = 4;
    localparam int RSEL_W    = $clog2(NUM_REGS);

    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [RSEL_W-1:0] rsel_t;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_EXEC  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    localparam byte_t      INS_HALT  = 8'h01;
    localparam logic [1:0] OP_SLI    = 2'b11;
    localparam logic [3:0] OP_STORE  = 4'b0011;
    localparam logic [3:0] OP_LOAD   = 4'b0010;
    localparam logic [3:0] OP_ADD    = 4'b0111;
    localparam logic [3:0] OP_SUB    = 4'b0001;
    localparam logic [3:0] OP_SKIP   = 4'b0100;
    localparam logic [3:0] OP_JALR   = 4'b0101;
    localparam logic [1:0] SKIP_NZ   = 2'b01;
    localparam logic [1:0] SKIP_Z    = 2'b00;

    typedef struct packed {
        logic  reg_we;
        rsel_t rd;
        byte_t reg_wdata;
        addr_t pc_next;
        logic  halt_set;
        logic  bad;
        logic  mem_we;
        logic  load;
        addr_t mem_addr;
        byte_t mem_wdata;
    } exec_res_t;

endpackage

/* rtl/tfrc_if.sv */
// ----------------------------------------------------------------------------
// tfrc_cmd_if / tfrc_rsp_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface tfrc_cmd_if;
    import tfrc_pkg::*;

    logic  valid;
    logic  ready;
    logic  [1:0] func;
    addr_t addr;
    byte_t wdata;

    modport source (output valid, output func, output addr, output wdata, input ready);
    modport sink (input valid, input func, input addr, input wdata, output ready);
endinterface

interface tfrc_rsp_if;
    import tfrc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rdata;
    addr_t pc_now;
    byte_t reg_a;
    byte_t reg_b;
    byte_t reg_c;
    byte_t reg_d;
    logic  is_halted;
    logic  bad_opcode;

    modport source (
        output valid, output rdata, output pc_now, output reg_a, output reg_b,
        output reg_c, output reg_d, output is_halted, output bad_opcode, input ready
    );
    modport sink (
        input valid, input rdata, input pc_now, input reg_a, input reg_b,
        input reg_c, input reg_d, input is_halted, input bad_opcode, output ready
    );
endinterface

/* rtl/tfrc_mem.sv */
// ----------------------------------------------------------------------------
// tfrc_mem
// Single-port 256-byte memory with registered read data. Per-byte valid
// flags make every location read as zero until it is first written.
// ----------------------------------------------------------------------------
module tfrc_mem (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           we,
    input  tfrc_pkg::addr_t addr,
    input  tfrc_pkg::byte_t wdata,
    output tfrc_pkg::byte_t rdata
);
    import tfrc_pkg::*;

    byte_t                mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    byte_t                rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en && we)
        begin
            vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= vld_reg[addr] ? mem[addr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tfrc_exec.sv */
// ----------------------------------------------------------------------------
// tfrc_exec
// Instruction decode and execute for one fetched byte: register results,
// next PC, halt, store and load requests.
// ----------------------------------------------------------------------------
module tfrc_exec (
    input  tfrc_pkg::byte_t     ins,
    input  tfrc_pkg::byte_t     regs [tfrc_pkg::NUM_REGS],
    input  tfrc_pkg::addr_t     pc,
    input  logic                halted,
    output tfrc_pkg::exec_res_t res
);
    import tfrc_pkg::*;

    rsel_t      dsel;
    logic [1:0] lo2;
    byte_t      dval;
    byte_t      sval;
    addr_t      pc_inc;

    assign dsel   = ins[3:2];
    assign lo2    = ins[1:0];
    assign dval   = regs[dsel];
    assign sval   = regs[lo2];
    assign pc_inc = pc + addr_t'(1);

    always_comb
    begin
        res           = '0;
        res.rd        = dsel;
        res.pc_next   = pc_inc;
        res.mem_addr  = sval;
        res.mem_wdata = dval;
        if (halted)
        begin
            res.pc_next = pc;
        end
        else if (ins == INS_HALT)
        begin
            res.halt_set = 1'b1;
        end
        else if (ins[7:6] == OP_SLI)
        begin
            res.reg_we    = 1'b1;
            res.reg_wdata = {dval[3:0], ins[5:4], lo2};
        end
        else
        begin
            case (ins[7:4])
                OP_STORE: res.mem_we = 1'b1;
                OP_LOAD:  res.load = 1'b1;
                OP_ADD:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = dval + sval;
                end
                OP_SUB:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = dval - sval;
                end
                OP_SKIP:
                begin
                    if (lo2 == SKIP_NZ)
                    begin
                        if (dval != '0)
                        begin
                            res.pc_next = pc_inc + addr_t'(1);
                        end
                    end
                    else if (lo2 == SKIP_Z)
                    begin
                        if (dval == '0)
                        begin
                            res.pc_next = pc_inc + addr_t'(1);
                        end
                    end
                    else
                    begin
                        res.bad = 1'b1;
                    end
                end
                OP_JALR:  res.pc_next = dval;
                default:  res.bad = 1'b1;
            endcase
        end
    end

endmodule

/* rtl/tiny_four_register_cpu.sv */
// ----------------------------------------------------------------------------
// tiny_four_register_cpu
// Four-register 8-bit processor around one 256-byte single-port memory.
//
//   Channel  Dir  Fields
//   cmd      in   func, addr, wdata
//   rsp      out  rdata, pc_now, reg_a, reg_b, reg_c, reg_d, is_halted, bad_opcode
//
// Memory writes, reads and non-memory instructions take one beat per cycle
// while the result channel is not stalled. A store or a load takes longer,
// since the single memory port serves the fetch and the data access in
// turn; a load's result beat also waits for an extra ST_LOAD state.
// After reset the memory reads as zero at once; there is no clearing pass.
// A stalled result holds the item in flight; a new beat is taken only when
// that item completes in the same cycle and leaves the memory port free.
// ----------------------------------------------------------------------------
`include "tiny_four_register_cpu_defines.svh"

module tiny_four_register_cpu (
    input  logic       clk,
    input  logic       rst_n,
    tfrc_cmd_if.sink   cmd,
    tfrc_rsp_if.source rsp
);
    import tfrc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DONE = 5'b00010,
        ST_READ = 5'b00100,
        ST_EXEC = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

    state_t    state_reg, state_next;
    addr_t     pc_reg, pc_next;
    byte_t     regs_reg [NUM_REGS];
    byte_t     regs_next [NUM_REGS];
    logic      halt_reg, halt_next;
    rsel_t     ld_dst_reg, ld_dst_next;

    logic      rsp_valid_reg;
    byte_t     rsp_rdata_reg;
    addr_t     rsp_pc_reg;
    byte_t     rsp_regs_reg [NUM_REGS];
    logic      rsp_halt_reg;
    logic      rsp_bad_reg;

    logic      mem_en, mem_we;
    addr_t     mem_addr;
    byte_t     mem_wdata, mem_rdata;

    exec_res_t ex;
    logic      in_exec, out_free, load_step, complete, store_now, accept;

    tfrc_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    tfrc_exec u_exec (
        .ins    (mem_rdata),
        .regs   (regs_reg),
        .pc     (pc_reg),
        .halted (halt_reg),
        .res    (ex)
    );

    assign in_exec   = (state_reg == ST_EXEC);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign load_step = in_exec && ex.load;
    assign complete  = out_free && ((state_reg == ST_DONE) || (state_reg == ST_READ)
                                    || (in_exec && !ex.load) || (state_reg == ST_LOAD));
    assign store_now = in_exec && complete && ex.mem_we;
    assign cmd.ready = (state_reg == ST_IDLE) || (complete && !store_now);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        pc_next     = pc_reg;
        regs_next   = regs_reg;
        halt_next   = halt_reg;
        ld_dst_next = ld_dst_reg;
        if (load_step)
        begin
            pc_next     = ex.pc_next;
            ld_dst_next = ex.rd;
        end
        else if (in_exec && complete)
        begin
            pc_next = ex.pc_next;
            if (ex.reg_we)
            begin
                regs_next[ex.rd] = ex.reg_wdata;
            end
            if (ex.halt_set)
            begin
                halt_next = 1'b1;
            end
        end
        else if ((state_reg == ST_LOAD) && complete)
        begin
            regs_next[ld_dst_reg] = mem_rdata;
        end
    end

    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = cmd.addr;
        mem_wdata = cmd.wdata;
        if (store_now)
        begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = ex.mem_addr;
            mem_wdata = ex.mem_wdata;
        end
        else if (load_step)
        begin
            mem_en   = 1'b1;
            mem_addr = ex.mem_addr;
        end
        else if (accept)
        begin
            case (func_t'(cmd.func))
                FUNC_WRITE:
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                end
                FUNC_READ:  mem_en = 1'b1;
                FUNC_EXEC:
                begin
                    mem_en   = 1'b1;
                    mem_addr = pc_next;
                end
                default:    mem_en = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (load_step)
        begin
            state_next = ST_LOAD;
        end
        else if ((state_reg == ST_IDLE) || complete)
        begin
            state_next = ST_IDLE;
            if (accept)
            begin
                case (func_t'(cmd.func))
                    FUNC_READ: state_next = ST_READ;
                    FUNC_EXEC: state_next = ST_EXEC;
                    default:   state_next = ST_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            regs_reg      <= '{default: '0};
            halt_reg      <= 1'b0;
            ld_dst_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            regs_reg   <= regs_next;
            halt_reg   <= halt_next;
            ld_dst_reg <= ld_dst_next;
            if (complete)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            rsp_rdata_reg <= (state_reg == ST_READ) ? mem_rdata : '0;
            rsp_pc_reg    <= pc_next;
            rsp_regs_reg  <= regs_next;
            rsp_halt_reg  <= halt_next;
            rsp_bad_reg   <= in_exec && ex.bad;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.rdata      = rsp_rdata_reg;
    assign rsp.pc_now     = rsp_pc_reg;
    assign rsp.reg_a      = rsp_regs_reg[0];
    assign rsp.reg_b      = rsp_regs_reg[1];
    assign rsp.reg_c      = rsp_regs_reg[2];
    assign rsp.reg_d      = rsp_regs_reg[3];
    assign rsp.is_halted  = rsp_halt_reg;
    assign rsp.bad_opcode = rsp_bad_reg;

    `TFRC_ASSERT_SAME(a_accept_slot_free, accept, (state_reg == ST_IDLE) || complete)
    `TFRC_ASSERT_SAME(a_store_owns_port, store_now, !accept)
    `TFRC_ASSERT_NEXT(a_load_follows_fetch, load_step, state_reg == ST_LOAD)
    `TFRC_ASSERT_NEXT(a_halt_sticks, halt_reg, halt_reg)

endmodule
